// File: hdl/square_matrix_multiply_core_defines.svh
// Assertion macros shared by the matrix multiply core.
`ifndef SQUARE_MATRIX_MULTIPLY_CORE_DEFINES_SVH
`define SQUARE_MATRIX_MULTIPLY_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SMM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SMM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/smm_pkg.sv
// Shared types and field widths of the matrix multiply core.
package smm_pkg;

   localparam int ELEM_W = 16;
   localparam int MUL_W  = 2 * ELEM_W;
   localparam int PROD_W = 33;
   localparam int IDX_W  = 2;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [MUL_W-1:0]  mul_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic [IDX_W-1:0]         idx_type;

   // Control that travels with each pair of operand reads.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } smm_tag_type;

endpackage

// File: hdl/smm_if.sv
// Request and response channel interfaces of the matrix multiply core.
interface smm_req_if import smm_pkg::*; ();
   logic     valid;
   logic     ready;
   elem_type element;

   modport source (output valid, output element, input ready);
   modport sink (input valid, input element, output ready);
endinterface

interface smm_rsp_if import smm_pkg::*; ();
   logic     valid;
   logic     ready;
   prod_type product_value;
   idx_type  row_index;
   idx_type  col_index;
   logic     last_entry;

   modport source (output valid, output product_value, output row_index,
                   output col_index, output last_entry, input ready);
   modport sink (input valid, input product_value, input row_index,
                 input col_index, input last_entry, output ready);
endinterface

// File: hdl/square_matrix_multiply_core.sv
// Square signed matrix multiplier, C = A x B, DIM x DIM, one shared MAC unit.
// The request channel takes 2*DIM*DIM signed 16-bit elements, one per request:
// A in row-major order, then B in row-major order. Elements load one per cycle.
// After the last element of B the core stops taking requests and computes the
// DIM*DIM entries of C in row-major order on a single multiply-accumulate unit.
// Each entry leaves on the response channel with its row, column and a last
// flag set on the final entry; then the core takes the next pair of matrices.
// Each entry takes DIM operand reads (one product per cycle through the MAC),
// then drains through the store read, multiply and accumulate registers into
// the response register. A stalled receiver holds the response register and
// the sequencer waits on it; nothing is lost. Synchronous reset returns the
// core to loading with the element count at zero and no response pending.
`include "square_matrix_multiply_core_defines.svh"

module square_matrix_multiply_core import smm_pkg::*; #(
   parameter int DIM = 3
) (
   input  logic      clock,
   input  logic      reset,
   smm_req_if.sink   req_if,
   smm_rsp_if.source rsp_if
);

   localparam int CELLS = DIM * DIM;
   localparam int TOTAL = 2 * CELLS;
   localparam int AW    = $clog2(CELLS);
   localparam int LW    = $clog2(TOTAL);
   localparam int IW    = $clog2(DIM);

   localparam logic [1:0] S_LOAD  = 2'd0;
   localparam logic [1:0] S_ISSUE = 2'd1;
   localparam logic [1:0] S_WAIT  = 2'd2;
   localparam logic [1:0] S_HOLD  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [LW-1:0] load_count_ff, load_count_in;
   logic [IW-1:0] k_ff, k_in;
   logic [IW-1:0] row_ff, row_in;
   logic [IW-1:0] col_ff, col_in;
   logic [AW-1:0] row_base_ff, row_base_in;
   logic [AW-1:0] a_ptr_ff, a_ptr_in;
   logic [AW-1:0] b_ptr_ff, b_ptr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   prod_type      product_ff, product_in;

   logic          req_accept;
   logic          rsp_accept;
   logic          load_in_b;
   logic          k_end;
   logic          row_end;
   logic          entry_last;
   smm_tag_type   tag;
   elem_type      a_data;
   elem_type      b_data;
   logic          mac_done;
   prod_type      mac_sum;

   assign req_if.ready = (state_ff == S_LOAD);
   assign req_accept   = req_if.valid && req_if.ready;
   assign rsp_accept   = rsp_valid_ff && rsp_if.ready;

   assign load_in_b  = (load_count_ff >= LW'(CELLS));
   assign k_end      = (k_ff == IW'(DIM - 1));
   assign row_end    = (col_ff == IW'(DIM - 1));
   assign entry_last = row_end && (row_ff == IW'(DIM - 1));

   assign tag = '{valid: (state_ff == S_ISSUE), first: (k_ff == '0), last: k_end};

   smm_mem #(.DEPTH(CELLS), .WIDTH(ELEM_W)) u_left_store (
      .clock   (clock),
      .wr_en   (req_accept && !load_in_b),
      .wr_addr (load_count_ff[AW-1:0]),
      .wr_data (req_if.element),
      .rd_en   (tag.valid),
      .rd_addr (a_ptr_ff),
      .rd_data (a_data)
   );

   smm_mem #(.DEPTH(CELLS), .WIDTH(ELEM_W)) u_right_store (
      .clock   (clock),
      .wr_en   (req_accept && load_in_b),
      .wr_addr (AW'(load_count_ff - LW'(CELLS))),
      .wr_data (req_if.element),
      .rd_en   (tag.valid),
      .rd_addr (b_ptr_ff),
      .rd_data (b_data)
   );

   smm_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .tag       (tag),
      .a_operand (a_data),
      .b_operand (b_data),
      .done      (mac_done),
      .sum       (mac_sum)
   );

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      k_in          = k_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      row_base_in   = row_base_ff;
      a_ptr_in      = a_ptr_ff;
      b_ptr_in      = b_ptr_ff;
      rsp_valid_in  = rsp_valid_ff;
      product_in    = product_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (req_accept) begin
               if (load_count_ff == LW'(TOTAL - 1)) begin
                  load_count_in = '0;
                  state_in      = S_ISSUE;
                  k_in          = '0;
                  row_in        = '0;
                  col_in        = '0;
                  row_base_in   = '0;
                  a_ptr_in      = '0;
                  b_ptr_in      = '0;
               end else begin
                  load_count_in = load_count_ff + LW'(1);
               end
            end
         end
         S_ISSUE: begin
            // A walks along the row, B walks down the column.
            a_ptr_in = a_ptr_ff + AW'(1);
            b_ptr_in = b_ptr_ff + AW'(DIM);
            if (k_end) begin
               k_in     = '0;
               state_in = S_WAIT;
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         S_WAIT: begin
            if (mac_done) begin
               rsp_valid_in = 1'b1;
               product_in   = mac_sum;
               state_in     = S_HOLD;
            end
         end
         S_HOLD: begin
            if (rsp_accept) begin
               rsp_valid_in = 1'b0;
               if (entry_last) begin
                  state_in = S_LOAD;
               end else if (row_end) begin
                  row_in      = row_ff + IW'(1);
                  col_in      = '0;
                  row_base_in = row_base_ff + AW'(DIM);
                  a_ptr_in    = row_base_ff + AW'(DIM);
                  b_ptr_in    = '0;
                  state_in    = S_ISSUE;
               end else begin
                  col_in   = col_ff + IW'(1);
                  a_ptr_in = row_base_ff;
                  b_ptr_in = AW'(col_ff) + AW'(1);
                  state_in = S_ISSUE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         load_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      row_base_ff <= row_base_in;
      a_ptr_ff    <= a_ptr_in;
      b_ptr_ff    <= b_ptr_in;
      product_ff  <= product_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.product_value = product_ff;
   assign rsp_if.row_index     = IDX_W'(row_ff);
   assign rsp_if.col_index     = IDX_W'(col_ff);
   assign rsp_if.last_entry    = entry_last;

   `SMM_ASSERT_SAME(a_no_overlap, clock, reset, rsp_valid_ff, !req_if.ready, "request taken while a product is pending")
   `SMM_ASSERT_SAME(a_done_in_wait, clock, reset, mac_done, state_ff == S_WAIT, "MAC finished outside the wait state")
   `SMM_ASSERT_NEXT(a_final_load, clock, reset, req_accept && (load_count_ff == LW'(TOTAL - 1)), (state_ff == S_ISSUE) && (load_count_ff == '0), "final element did not start the product")
   `SMM_ASSERT_NEXT(a_last_out, clock, reset, rsp_accept && entry_last, state_ff == S_LOAD, "core did not return to loading after the last entry")

endmodule

// File: hdl/smm_mem.sv
// Single-port-write, single-port-read matrix store with registered read data.
module smm_mem #(
   parameter int DEPTH = 9,
   parameter int WIDTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/smm_mac.sv
// Shared multiply-accumulate unit: registered multiply, then a 33-bit accumulator.
module smm_mac import smm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  smm_tag_type tag,
   input  elem_type    a_operand,
   input  elem_type    b_operand,
   output logic        done,
   output prod_type    sum
);

   smm_tag_type tag_d1_ff;
   smm_tag_type tag_d2_ff;
   mul_type     prod_ff;
   prod_type    acc_ff;
   logic        done_ff;
   prod_type    prod_ext;

   // Operands show up in the cycle after the tag, from the stores' read registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_d1_ff <= '0;
         tag_d2_ff <= '0;
         done_ff   <= 1'b0;
      end else begin
         tag_d1_ff <= tag;
         tag_d2_ff <= tag_d1_ff;
         done_ff   <= tag_d2_ff.valid && tag_d2_ff.last;
      end
   end

   assign prod_ext = {{(PROD_W - MUL_W){prod_ff[MUL_W-1]}}, prod_ff};

   always_ff @(posedge clock) begin
      if (tag_d1_ff.valid) begin
         prod_ff <= a_operand * b_operand;
      end
      if (tag_d2_ff.valid) begin
         acc_ff <= tag_d2_ff.first ? prod_ext : acc_ff + prod_ext;
      end
   end

   assign done = done_ff;
   assign sum  = acc_ff;

endmodule

// File: test/tb_top.sv
// Self-checking testbench of the 3x3 signed matrix multiply core.
`timescale 1ns / 1ps

module tb_top;
   import smm_pkg::*;

   localparam int DIM        = 3;
   localparam int CELLS      = DIM * DIM;
   localparam int LOAD_TOTAL = 2 * CELLS;
   localparam int DRAIN_WAIT = 4 * (DIM + 4);
   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_MAX = 10;

   typedef struct {
      prod_type value;
      idx_type  row;
      idx_type  col;
      logic     last;
   } product_entry_type;

   typedef enum int {
      FILL_FULL    = 0,
      FILL_EXTREME = 1,
      FILL_SMALL   = 2
   } fill_mode_type;

   logic clock;
   logic reset;

   smm_req_if req_ch ();
   smm_rsp_if rsp_ch ();

   square_matrix_multiply_core #(.DIM(DIM)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Predictor state: copies of both operand matrices and the element count.
   elem_type left_cells [CELLS];
   elem_type right_cells [CELLS];
   int       elements_loaded;

   product_entry_type product_queue [$];

   int send_idle_pct;
   int rsp_stall_pct;
   int fail_count;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Store one accepted element; the last element of B yields the whole product.
   task automatic load_element(input elem_type elem);
      longint            acc;
      product_entry_type entry;
      if (elements_loaded < CELLS) begin
         left_cells[elements_loaded] = elem;
      end else begin
         right_cells[elements_loaded - CELLS] = elem;
      end
      elements_loaded++;
      if (elements_loaded == LOAD_TOTAL) begin
         for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
               acc = 0;
               for (int k = 0; k < DIM; k++) begin
                  acc += longint'(left_cells[r * DIM + k]) *
                         longint'(right_cells[k * DIM + c]);
               end
               entry.value = prod_type'(acc);
               entry.row   = idx_type'(r);
               entry.col   = idx_type'(c);
               entry.last  = (r == DIM - 1) && (c == DIM - 1);
               product_queue.push_back(entry);
            end
         end
         elements_loaded = 0;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         load_element(req_ch.element);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Compare every accepted response with the oldest predicted entry.
   always @(posedge clock) begin
      product_entry_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (product_queue.size() == 0) begin
            if (fail_count < REPORT_MAX) begin
               $display("unexpected response: value %0d row %0d col %0d last %0d",
                        rsp_ch.product_value, rsp_ch.row_index, rsp_ch.col_index,
                        rsp_ch.last_entry);
            end
            fail_count++;
         end else begin
            want = product_queue.pop_front();
            if (rsp_ch.product_value !== want.value || rsp_ch.row_index !== want.row ||
                rsp_ch.col_index !== want.col || rsp_ch.last_entry !== want.last) begin
               if (fail_count < REPORT_MAX) begin
                  $display("mismatch: expected value %0d row %0d col %0d last %0d",
                           want.value, want.row, want.col, want.last);
                  $display("          actual   value %0d row %0d col %0d last %0d",
                           rsp_ch.product_value, rsp_ch.row_index, rsp_ch.col_index,
                           rsp_ch.last_entry);
               end
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_top failed");
         $finish;
      end
   end

   // Present one request and hold it until the core takes it.
   task automatic send_element(input elem_type elem);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.element <= elem;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
   endtask

   function automatic elem_type pick_element(input fill_mode_type mode);
      int sel;
      sel = $urandom_range(4);
      case (mode)
         FILL_EXTREME: begin
            case (sel)
               0: return elem_type'(16'sh8000);
               1: return elem_type'(16'sh7fff);
               2: return elem_type'(0);
               3: return elem_type'(-1);
               default: return elem_type'(1);
            endcase
         end
         FILL_SMALL: return elem_type'(int'($urandom_range(16)) - 8);
         default: return elem_type'($urandom);
      endcase
   endfunction

   // Rows of A at full negative, full positive and mixed small values against
   // columns of B at full negative, full positive and small values: this hits
   // the largest and the smallest possible product entries in one pair.
   task automatic test_extreme_values();
      elem_type a_vals [CELLS];
      elem_type b_vals [CELLS];
      a_vals = '{16'sh8000, 16'sh8000, 16'sh8000,
                 16'sh7fff, 16'sh7fff, 16'sh7fff,
                 0,         1,         -1};
      b_vals = '{16'sh8000, 16'sh7fff, 1,
                 16'sh8000, 16'sh7fff, -1,
                 16'sh8000, 16'sh7fff, 0};
      foreach (a_vals[i]) send_element(a_vals[i]);
      foreach (b_vals[i]) send_element(b_vals[i]);
   endtask

   task automatic test_random_matrices(input int idle_pct, input int stall_pct,
                                       input int pairs);
      fill_mode_type mode;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int p = 0; p < pairs; p++) begin
         mode = fill_mode_type'($urandom_range(5) < 3 ? FILL_FULL :
                                ($urandom_range(1) ? FILL_EXTREME : FILL_SMALL));
         for (int i = 0; i < LOAD_TOTAL; i++) begin
            send_element(pick_element(mode));
         end
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.element  = '0;
      rsp_ch.ready    = 1'b0;
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      fail_count      = 0;
      cycle_count     = 0;
      elements_loaded = 0;
      foreach (left_cells[i]) left_cells[i] = '0;
      foreach (right_cells[i]) right_cells[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extreme_values();
      test_random_matrices(0, 0, 4);
      test_random_matrices(77, 0, 4);
      test_random_matrices(0, 77, 4);
      test_random_matrices(34, 34, 4);
      req_ch.valid <= 1'b0;

      // let the predictor take the final request before watching the queue
      @(posedge clock);
      while (product_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (fail_count == 0 && product_queue.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
